// ===== rtl/core/scc_pkg.sv =====
// shared types and constants for the spike cross-correlogram engine
// no dependencies
`default_nettype none
package scc_pkg;

    localparam int MaxClusters = 16;
    localparam int NumBins     = 64;
    localparam int WinDepth    = 64;

    localparam int TimeW  = 40;
    localparam int LabW   = 4;
    localparam int BinW   = 6;
    localparam int HAddrW = 2 * LabW + BinW;
    localparam int SpanW  = 22;
    localparam int WPtrW  = 6;
    localparam int WFillW = 7;
    localparam int CountW = 32;

    localparam logic [1:0] CMD_EVENT = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0] REG_BIN_WIDTH = 8'd0;
    localparam logic [7:0] REG_HALF_BINS = 8'd1;
    localparam logic [7:0] REG_PAIR_MODE = 8'd2;
    localparam logic [7:0] REG_MASK      = 8'd3;

    typedef enum logic [2:0] {
        K_EVENT = 3'd0,
        K_BAD   = 3'd1,
        K_READ  = 3'd2,
        K_NOP   = 3'd3,
        K_CLEAR = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [TimeW-1:0]   t;
        logic [LabW-1:0]    lab;
        logic [HAddrW-1:0]  hidx;
    } op_t;

    typedef struct packed {
        logic [CountW-1:0]  count;
        logic               ovf;
        logic               bad;
    } res_t;

    typedef struct packed {
        logic [15:0] bin_width;
        logic [5:0]  half_bins;
        logic        pair_mode;
        logic [15:0] mask;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/scc_front.sv =====
// front end: accepts commands, decodes them and holds them in a two-word queue
// depends on scc_pkg
`default_nettype none
module scc_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [1:0]               cmd,
    input  wire logic [scc_pkg::TimeW-1:0] spike_time,
    input  wire logic [4:0]               spike_label,
    input  wire logic [4:0]               read_first_cluster,
    input  wire logic [4:0]               read_second_cluster,
    input  wire logic [5:0]               read_bin,
    output logic                          op_valid,
    output scc_pkg::op_t                  op,
    input  wire logic                     op_take
);
    import scc_pkg::*;

    op_t        q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    op_t        dec;
    logic       acc;
    logic [4:0] k1m, k2m, labm;

    always_comb
    begin
        k1m  = read_first_cluster - 5'd1;
        k2m  = read_second_cluster - 5'd1;
        labm = spike_label - 5'd1;
        dec.t    = spike_time;
        dec.lab  = labm[LabW-1:0];
        dec.hidx = {k1m[LabW-1:0], k2m[LabW-1:0], read_bin};
        unique case (cmd)
            CMD_EVENT:
                dec.kind = (spike_label == 5'd0 || spike_label > 5'(MaxClusters))
                           ? K_BAD : K_EVENT;
            CMD_READ:
                dec.kind = (read_first_cluster == 5'd0
                            || read_first_cluster > 5'(MaxClusters)
                            || read_second_cluster == 5'd0
                            || read_second_cluster > 5'(MaxClusters)) ? K_NOP : K_READ;
            CMD_CLEAR: dec.kind = K_CLEAR;
            default:   dec.kind = K_NOP;
        endcase
    end

    assign full     = (cnt_reg == 2'd2);
    assign acc      = push && !full;
    assign op_valid = (cnt_reg != 2'd0);
    assign op       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = acc ? ~wp_reg : wp_reg;
        rp_next  = (op_take && op_valid) ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, acc} - {1'b0, op_take && op_valid};
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wp_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/scc_back.sv =====
// back end: window ring, lag division and histogram memory sequencer
// depends on scc_pkg
`default_nettype none
module scc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire scc_pkg::cfg_t cfg,
    input  wire logic          op_valid,
    input  wire scc_pkg::op_t  op,
    output logic               op_take,
    output logic               res_push,
    output scc_pkg::res_t      res,
    input  wire logic          res_full
);
    import scc_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_CLR      = 16'h0002,
        S_AGE      = 16'h0004,
        S_AGE_CHK  = 16'h0008,
        S_SCAN     = 16'h0010,
        S_SCAN_CHK = 16'h0020,
        S_DIV      = 16'h0040,
        S_B1       = 16'h0080,
        S_B2       = 16'h0100,
        S_SELF     = 16'h0200,
        S_HRD      = 16'h0400,
        S_HWR      = 16'h0800,
        S_RDQ      = 16'h1000,
        S_RDD      = 16'h2000,
        S_STORE    = 16'h4000,
        S_OUT      = 16'h8000
    } state_t;

    logic [CountW-1:0]     hist [MaxClusters*MaxClusters*NumBins];
    logic [TimeW+LabW-1:0] wmem [WinDepth];

    state_t              state_reg, state_next, ret_reg, ret_next;
    logic [WPtrW-1:0]    head_reg, head_next;
    logic [WFillW-1:0]   fill_reg, fill_next, i_reg, i_next;
    logic [HAddrW-1:0]   clr_reg, clr_next, baddr_reg, baddr_next;
    logic                init_reg, init_next;
    logic [TimeW-1:0]    t_reg, t_next;
    logic [LabW-1:0]     lab_reg, lab_next, la_reg, la_next;
    logic [5:0]          r_reg, r_next, q_reg, q_next;
    logic [15:0]         w_reg, w_next;
    logic [SpanW-1:0]    span_reg, span_next, d_reg, d_next, rem_reg, rem_next;
    logic [2:0]          k_reg, k_next;
    logic                selb_reg, selb_next;
    res_t                res_reg, res_next;

    logic [CountW-1:0]     hdata_reg;
    logic [TimeW+LabW-1:0] wdata_reg;
    logic                  h_re, h_we, w_re, w_we;
    logic [HAddrW-1:0]     h_waddr;
    logic [CountW-1:0]     h_wdata;
    logic [WPtrW-1:0]      w_raddr, w_waddr;

    logic [TimeW-1:0]  ta, dfull;
    logic [LabW-1:0]   la;
    logic [SpanW-1:0]  dsh;
    logic [5:0]        r_c, bin2;
    logic [15:0]       w_c;
    logic              far;

    always_comb
    begin
        ta    = wdata_reg[TimeW+LabW-1:LabW];
        la    = wdata_reg[LabW-1:0];
        dfull = t_reg - ta;
        far   = (dfull[TimeW-1:SpanW] != '0) || (dfull[SpanW-1:0] > span_reg);
        dsh   = SpanW'(w_reg) << k_reg;
        bin2  = r_reg - q_reg - {5'd0, rem_reg != '0};
        w_c   = (cfg.bin_width == 16'd0) ? 16'd1 : cfg.bin_width;
        if (cfg.half_bins == 6'd0)
            r_c = 6'd1;
        else if (cfg.half_bins > 6'(NumBins / 2))
            r_c = 6'(NumBins / 2);
        else
            r_c = cfg.half_bins;
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        i_next     = i_reg;
        clr_next   = clr_reg;
        baddr_next = baddr_reg;
        init_next  = init_reg;
        t_next     = t_reg;
        lab_next   = lab_reg;
        la_next    = la_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        w_next     = w_reg;
        span_next  = span_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        k_next     = k_reg;
        selb_next  = selb_reg;
        res_next   = res_reg;
        op_take    = 1'b0;
        res_push   = 1'b0;
        h_re       = 1'b0;
        h_we       = 1'b0;
        h_waddr    = baddr_reg;
        h_wdata    = (hdata_reg == '1) ? hdata_reg : hdata_reg + 1'b1;
        w_re       = 1'b0;
        w_we       = 1'b0;
        w_raddr    = head_reg + i_reg[WPtrW-1:0];
        w_waddr    = head_reg + fill_reg[WPtrW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    op_take  = 1'b1;
                    res_next = '0;
                    unique case (op.kind)
                        K_EVENT:
                        begin
                            t_next     = op.t;
                            lab_next   = op.lab;
                            r_next     = r_c;
                            w_next     = w_c;
                            span_next  = {16'd0, r_c} * {6'd0, w_c};
                            selb_next  = cfg.mask[op.lab];
                            state_next = S_AGE;
                        end
                        K_BAD:
                        begin
                            res_next.bad = 1'b1;
                            state_next   = S_OUT;
                        end
                        K_READ:
                        begin
                            baddr_next = op.hidx;
                            state_next = S_RDQ;
                        end
                        K_CLEAR:
                        begin
                            head_next  = '0;
                            fill_next  = '0;
                            clr_next   = '0;
                            state_next = S_CLR;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_CLR:
            begin
                h_we     = 1'b1;
                h_waddr  = clr_reg;
                h_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_OUT;
                end
            end
            S_AGE:
            begin
                if (fill_reg == '0)
                begin
                    i_next     = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    w_re       = 1'b1;
                    w_raddr    = head_reg;
                    state_next = S_AGE_CHK;
                end
            end
            S_AGE_CHK:
            begin
                if (ta > t_reg || !far)
                begin
                    i_next     = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    fill_next  = fill_reg - 1'b1;
                    state_next = S_AGE;
                end
            end
            S_SCAN:
            begin
                if (i_reg == fill_reg)
                begin
                    state_next = S_SELF;
                end
                else
                begin
                    w_re       = 1'b1;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (ta > t_reg || !selb_reg || !cfg.mask[la]
                    || (!cfg.pair_mode && la != lab_reg) || far)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    d_next     = dfull[SpanW-1:0];
                    rem_next   = dfull[SpanW-1:0];
                    q_next     = '0;
                    k_next     = 3'd5;
                    la_next    = la;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_reg >= dsh)
                begin
                    rem_next         = rem_reg - dsh;
                    q_next[k_reg]    = 1'b1;
                end
                k_next = k_reg - 1'b1;
                if (k_reg == 3'd0)
                    state_next = S_B1;
            end
            S_B1:
            begin
                if (d_reg < span_reg)
                begin
                    baddr_next = {la_reg, lab_reg, q_reg + r_reg};
                    ret_next   = S_B2;
                    state_next = S_HRD;
                end
                else
                begin
                    state_next = S_B2;
                end
            end
            S_B2:
            begin
                baddr_next = {lab_reg, la_reg, bin2};
                i_next     = i_reg + 1'b1;
                ret_next   = S_SCAN;
                state_next = S_HRD;
            end
            S_SELF:
            begin
                if (selb_reg)
                begin
                    baddr_next = {lab_reg, lab_reg, r_reg};
                    ret_next   = S_STORE;
                    state_next = S_HRD;
                end
                else
                begin
                    state_next = S_STORE;
                end
            end
            S_HRD:
            begin
                h_re       = 1'b1;
                state_next = S_HWR;
            end
            S_HWR:
            begin
                h_we       = 1'b1;
                state_next = ret_reg;
            end
            S_RDQ:
            begin
                h_re       = 1'b1;
                state_next = S_RDD;
            end
            S_RDD:
            begin
                res_next.count = hdata_reg;
                state_next     = S_OUT;
            end
            S_STORE:
            begin
                w_we = 1'b1;
                if (fill_reg == WFillW'(WinDepth))
                begin
                    w_waddr      = head_reg;
                    head_next    = head_reg + 1'b1;
                    res_next.ovf = 1'b1;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (h_we)
            hist[h_waddr] <= h_wdata;
        if (h_re)
            hdata_reg <= hist[baddr_reg];
        if (w_we)
            wmem[w_waddr] <= {t_reg, lab_reg};
        if (w_re)
            wdata_reg <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        lab_reg   <= lab_next;
        la_reg    <= la_next;
        r_reg     <= r_next;
        q_reg     <= q_next;
        w_reg     <= w_next;
        span_reg  <= span_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        k_reg     <= k_next;
        selb_reg  <= selb_next;
        res_reg   <= res_next;
        baddr_reg <= baddr_next;
        ret_reg   <= ret_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            init_reg  <= 1'b1;
            clr_reg   <= '0;
            head_reg  <= '0;
            fill_reg  <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            i_reg     <= i_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/scc_res_queue.sv =====
// two-word result queue between the back end and the result ports
// depends on scc_pkg
`default_nettype none
module scc_res_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          res_push,
    input  wire scc_pkg::res_t res,
    output logic               res_full,
    output logic               empty,
    input  wire logic          pop,
    output scc_pkg::res_t      head
);
    import scc_pkg::*;

    res_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign wr       = res_push && !res_full;
    assign rd       = pop && !empty;
    assign head     = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            q_reg[wp_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_reg ^ wr;
            rp_reg  <= rp_reg ^ rd;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/spike_cross_correlogram.sv =====
// top level of the spike cross-correlogram engine: config registers and wiring
// depends on scc_pkg, scc_front, scc_back, scc_res_queue
//
// channel   direction  handshake          word
// command   in         push / full        cmd, spike_time, spike_label, read_*
// result    out        empty / pop        bin_count, window_overflow, bad_label
// config    in         cfg_we             cfg_index, cfg_wdata
//
// the per-pair work of an event is the 6-step lag divider and up to two
// histogram read-modify-writes
// a clear writes one histogram word per cycle
// after reset the same clearing pass runs before the first command
// both sides stall on their own through the command and result queues
`default_nettype none
module spike_cross_correlogram (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [1:0]                cmd,
    input  wire logic [scc_pkg::TimeW-1:0] spike_time,
    input  wire logic [4:0]                spike_label,
    input  wire logic [4:0]                read_first_cluster,
    input  wire logic [4:0]                read_second_cluster,
    input  wire logic [5:0]                read_bin,
    output logic                           empty,
    input  wire logic                      pop,
    output logic [scc_pkg::CountW-1:0]     bin_count,
    output logic                           window_overflow,
    output logic                           bad_label,
    input  wire logic                      cfg_we,
    input  wire logic [7:0]                cfg_index,
    input  wire logic [15:0]               cfg_wdata
);
    import scc_pkg::*;

    cfg_t cfg_reg, cfg_next;
    op_t  op;
    res_t res, head;
    logic op_valid, op_take, res_push, res_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIN_WIDTH: cfg_next.bin_width = cfg_wdata;
                REG_HALF_BINS: cfg_next.half_bins = cfg_wdata[5:0];
                REG_PAIR_MODE: cfg_next.pair_mode = cfg_wdata[0];
                REG_MASK:      cfg_next.mask      = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bin_width <= 16'd30;
            cfg_reg.half_bins <= 6'd16;
            cfg_reg.pair_mode <= 1'b1;
            cfg_reg.mask      <= 16'hFFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    scc_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .cmd                 (cmd),
        .spike_time          (spike_time),
        .spike_label         (spike_label),
        .read_first_cluster  (read_first_cluster),
        .read_second_cluster (read_second_cluster),
        .read_bin            (read_bin),
        .op_valid            (op_valid),
        .op                  (op),
        .op_take             (op_take)
    );

    scc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full)
    );

    scc_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign bin_count       = head.count;
    assign window_overflow = head.ovf;
    assign bad_label       = head.bad;

endmodule
`default_nettype wire
